/* sv/sfr_pkg.sv */
// shared constants and control structs for the stream find-and-replace block
package sfr_pkg;

   // default sizes of the pattern and replacement
   localparam int MAX_PATTERN_DEF = 8;
   localparam int MAX_REPLACE_DEF = 8;

   // character and configuration port widths
   localparam int BYTE_W     = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 64;
   localparam int LEN_W      = 4;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MATCH_PATTERN   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MATCH_LEN       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REPLACE_PATTERN = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REPLACE_LEN     = 2'd3;

   // control of one window cell
   typedef struct packed {
      logic sel_new;  // new byte lands in this cell
      logic load;     // write the new byte this cycle
      logic shift;    // take the neighbour's byte this cycle
      logic active;   // cell lies inside the pattern length
   } win_ctrl_type;

   // control of one emission cell
   typedef struct packed {
      logic load;     // start a new run of results
      logic use_rep;  // run takes replacement bytes, not window bytes
      logic shift;    // one result leaves the head this cycle
   } emit_ctrl_type;

endpackage

/* sv/sfr_channels.sv */
// handshake channels for the text input and the rewritten output
interface sfr_req_if;
   logic                         valid;
   logic                         ready;
   logic [sfr_pkg::BYTE_W-1:0]   in_byte;
   logic                         is_final;

   modport source (output valid, output in_byte, output is_final, input ready);
   modport sink   (input valid, input in_byte, input is_final, output ready);
endinterface

interface sfr_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [sfr_pkg::BYTE_W-1:0]   out_byte;
   logic                         has_byte;
   logic                         run_last;
   logic                         text_end;

   modport source (output valid, output out_byte, output has_byte, output run_last,
                   output text_end, input ready);
   modport sink   (input valid, input out_byte, input has_byte, input run_last,
                   input text_end, output ready);
endinterface

/* sv/sfr_window_cell.sv */
// one cell of the pending window: holds a byte and compares it with its pattern byte
module sfr_window_cell (
   input  logic                        clock,
   input  sfr_pkg::win_ctrl_type       ctrl,
   input  logic [sfr_pkg::BYTE_W-1:0]  in_byte,
   input  logic [sfr_pkg::BYTE_W-1:0]  next_byte,
   input  logic [sfr_pkg::BYTE_W-1:0]  pat_byte,
   input  logic                        hit_in,
   output logic [sfr_pkg::BYTE_W-1:0]  eff_byte,
   output logic                        hit_out
);

   logic [sfr_pkg::BYTE_W-1:0] byte_ff;
   logic [sfr_pkg::BYTE_W-1:0] byte_in;

   // window content as seen with the incoming byte appended
   assign eff_byte = ctrl.sel_new ? in_byte : byte_ff;

   // match chain: cells past the pattern length always agree
   assign hit_out = hit_in && (!ctrl.active || (eff_byte == pat_byte));

   // shift towards the oldest end on a miss, else append
   always_comb begin
      byte_in = byte_ff;
      if (ctrl.shift) begin
         byte_in = next_byte;
      end else if (ctrl.load) begin
         byte_in = in_byte;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

endmodule

/* sv/sfr_emit_cell.sv */
// one cell of the emission line: loads a window or replacement byte, shifts to the head
module sfr_emit_cell (
   input  logic                        clock,
   input  sfr_pkg::emit_ctrl_type      ctrl,
   input  logic [sfr_pkg::BYTE_W-1:0]  win_byte,
   input  logic [sfr_pkg::BYTE_W-1:0]  rep_byte,
   input  logic [sfr_pkg::BYTE_W-1:0]  next_byte,
   output logic [sfr_pkg::BYTE_W-1:0]  cur_byte
);

   logic [sfr_pkg::BYTE_W-1:0] byte_ff;
   logic [sfr_pkg::BYTE_W-1:0] byte_in;

   // a new run overrides the shift of the run that is leaving
   always_comb begin
      byte_in = byte_ff;
      if (ctrl.load) begin
         byte_in = ctrl.use_rep ? rep_byte : win_byte;
      end else if (ctrl.shift) begin
         byte_in = next_byte;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign cur_byte = byte_ff;

endmodule

/* sv/stream_find_replace_unit.sv */
// top level of the streaming find-and-replace block
//
// Rewrites a byte stream, replacing each non-overlapping occurrence of the
// configured pattern (1 to MAX_PATTERN bytes) with the replacement (0 to
// MAX_REPLACE bytes), scanning left to right. Pending bytes sit in a row of
// window cells that compare against the pattern as the new byte arrives; the
// results of one input are loaded into a row of emission cells and leave one
// per cycle through an output register unless the output stalls. Inputs that
// cause zero or one result flow at one per cycle unless the output stalls; an
// input that causes n results (up to max(MAX_PATTERN, MAX_REPLACE), including
// the flush on a final byte) holds off the next input until the last of them
// leaves the emission line. A final byte with nothing left to emit gives a
// single end marker with has_byte low. Writing match_len discards the pending
// window; the user must write configuration only while the block is idle, as
// the block does not enforce it. There is no clearing pass after reset.
module stream_find_replace_unit #(
   parameter int MAX_PATTERN = sfr_pkg::MAX_PATTERN_DEF,
   parameter int MAX_REPLACE = sfr_pkg::MAX_REPLACE_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [sfr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sfr_pkg::CSR_DATA_W-1:0]    csr_data,
   sfr_req_if.sink                           req_bus,
   sfr_rsp_if.source                         rsp_bus
);

   localparam int ED = (MAX_PATTERN > MAX_REPLACE) ? MAX_PATTERN : MAX_REPLACE;
   localparam int CW = $clog2(MAX_PATTERN + 1);
   localparam int EW = $clog2(ED + 1);
   localparam int BW = sfr_pkg::BYTE_W;
   localparam int LW = sfr_pkg::LEN_W;
   localparam int DW = sfr_pkg::CSR_DATA_W;

   // configuration registers
   logic [DW-1:0] match_pattern_ff, match_pattern_in;
   logic [LW-1:0] match_len_ff, match_len_in;
   logic [DW-1:0] replace_pattern_ff, replace_pattern_in;
   logic [LW-1:0] replace_len_ff, replace_len_in;

   // window and emission control state
   logic [CW-1:0] count_ff, count_in;
   logic [EW-1:0] emit_left_ff, emit_left_in;
   logic          emit_final_ff, emit_final_in;
   logic          emit_mark_ff, emit_mark_in;

   // output register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [BW-1:0] rsp_byte_ff, rsp_byte_in;
   logic          rsp_has_ff, rsp_has_in;
   logic          rsp_last_ff, rsp_last_in;
   logic          rsp_end_ff, rsp_end_in;

   logic [CW-1:0] mlen;
   logic [EW-1:0] rlen;
   logic [CW-1:0] count_new;
   logic          accept, full, hit, miss;
   logic [EW-1:0] n_job, n_total;
   logic          mark_new, start, out_take;

   sfr_pkg::win_ctrl_type  win_ctrl  [MAX_PATTERN];
   sfr_pkg::emit_ctrl_type emit_ctrl;
   logic [BW-1:0]          win_eff   [MAX_PATTERN];
   logic                   hit_chain [MAX_PATTERN+1];
   logic [BW-1:0]          emit_byte [ED];

   // effective lengths: zero pattern length counts as one, both saturate
   always_comb begin
      if (match_len_ff == '0) begin
         mlen = CW'(1);
      end else if (match_len_ff > LW'(MAX_PATTERN)) begin
         mlen = CW'(MAX_PATTERN);
      end else begin
         mlen = CW'(match_len_ff);
      end
      if (replace_len_ff > LW'(MAX_REPLACE)) begin
         rlen = EW'(MAX_REPLACE);
      end else begin
         rlen = EW'(replace_len_ff);
      end
   end

   // configuration writes
   always_comb begin
      match_pattern_in   = match_pattern_ff;
      match_len_in       = match_len_ff;
      replace_pattern_in = replace_pattern_ff;
      replace_len_in     = replace_len_ff;
      if (csr_we) begin
         case (csr_index)
            sfr_pkg::CSR_MATCH_PATTERN:   match_pattern_in   = csr_data;
            sfr_pkg::CSR_MATCH_LEN:       match_len_in       = csr_data[LW-1:0];
            sfr_pkg::CSR_REPLACE_PATTERN: replace_pattern_in = csr_data;
            sfr_pkg::CSR_REPLACE_LEN:     replace_len_in     = csr_data[LW-1:0];
            default: ;
         endcase
      end
   end

   // input transfer and window decision
   assign out_take      = (emit_left_ff != '0) && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = (emit_left_ff == '0) || ((emit_left_ff == EW'(1)) && out_take);
   assign accept        = req_bus.valid && req_bus.ready;
   assign count_new     = count_ff + CW'(1);
   assign full          = (count_new == mlen);
   assign hit           = full && hit_chain[MAX_PATTERN];
   assign miss          = full && !hit_chain[MAX_PATTERN];

   // row of window cells
   assign hit_chain[0] = 1'b1;
   for (genvar gi = 0; gi < MAX_PATTERN; gi++) begin : g_win
      logic [BW-1:0] next_byte;
      if (gi == MAX_PATTERN - 1) begin : g_tail
         assign next_byte = '0;
      end else begin : g_body
         assign next_byte = win_eff[gi+1];
      end
      always_comb begin
         win_ctrl[gi].sel_new = (count_ff == CW'(gi));
         win_ctrl[gi].load    = accept && (count_ff == CW'(gi));
         win_ctrl[gi].shift   = accept && miss;
         win_ctrl[gi].active  = (CW'(gi) < mlen);
      end
      sfr_window_cell u_cell (
         .clock     (clock),
         .ctrl      (win_ctrl[gi]),
         .in_byte   (req_bus.in_byte),
         .next_byte (next_byte),
         .pat_byte  (match_pattern_ff[BW*gi +: BW]),
         .hit_in    (hit_chain[gi]),
         .eff_byte  (win_eff[gi]),
         .hit_out   (hit_chain[gi+1])
      );
   end

   // size of the run of results caused by this input
   always_comb begin
      if (hit) begin
         n_job = rlen;
      end else if (miss) begin
         n_job = req_bus.is_final ? EW'(mlen) : EW'(1);
      end else begin
         n_job = req_bus.is_final ? EW'(count_new) : '0;
      end
      mark_new = req_bus.is_final && (n_job == '0);
      n_total  = mark_new ? EW'(1) : n_job;
   end

   assign start = accept && (n_total != '0);

   // row of emission cells
   assign emit_ctrl.load    = start;
   assign emit_ctrl.use_rep = hit;
   assign emit_ctrl.shift   = out_take;

   for (genvar gj = 0; gj < ED; gj++) begin : g_emit
      logic [BW-1:0] win_src, rep_src, next_src;
      if (gj < MAX_PATTERN) begin : g_win_src
         assign win_src = win_eff[gj];
      end else begin : g_no_win
         assign win_src = '0;
      end
      if (gj < MAX_REPLACE) begin : g_rep_src
         assign rep_src = replace_pattern_ff[BW*gj +: BW];
      end else begin : g_no_rep
         assign rep_src = '0;
      end
      if (gj == ED - 1) begin : g_tail
         assign next_src = '0;
      end else begin : g_body
         assign next_src = emit_byte[gj+1];
      end
      sfr_emit_cell u_cell (
         .clock     (clock),
         .ctrl      (emit_ctrl),
         .win_byte  (win_src),
         .rep_byte  (rep_src),
         .next_byte (next_src),
         .cur_byte  (emit_byte[gj])
      );
   end

   // window count, run bookkeeping and output register
   always_comb begin
      count_in      = count_ff;
      emit_left_in  = emit_left_ff;
      emit_final_in = emit_final_ff;
      emit_mark_in  = emit_mark_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_has_in    = rsp_has_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_end_in    = rsp_end_ff;

      if (accept) begin
         if (hit || req_bus.is_final) begin
            count_in = '0;
         end else if (!full) begin
            count_in = count_new;
         end
      end
      if (csr_we && (csr_index == sfr_pkg::CSR_MATCH_LEN)) begin
         count_in = '0;
      end

      if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (out_take) begin
         emit_left_in = emit_left_ff - EW'(1);
         rsp_valid_in = 1'b1;
         rsp_byte_in  = emit_mark_ff ? '0 : emit_byte[0];
         rsp_has_in   = !emit_mark_ff;
         rsp_last_in  = (emit_left_ff == EW'(1));
         rsp_end_in   = (emit_left_ff == EW'(1)) && emit_final_ff;
      end
      if (start) begin
         emit_left_in  = n_total;
         emit_final_in = req_bus.is_final;
         emit_mark_in  = mark_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_pattern_ff   <= '0;
         match_len_ff       <= LW'(1);
         replace_pattern_ff <= '0;
         replace_len_ff     <= '0;
         count_ff           <= '0;
         emit_left_ff       <= '0;
         emit_final_ff      <= 1'b0;
         emit_mark_ff       <= 1'b0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         match_pattern_ff   <= match_pattern_in;
         match_len_ff       <= match_len_in;
         replace_pattern_ff <= replace_pattern_in;
         replace_len_ff     <= replace_len_in;
         count_ff           <= count_in;
         emit_left_ff       <= emit_left_in;
         emit_final_ff      <= emit_final_in;
         emit_mark_ff       <= emit_mark_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff <= rsp_byte_in;
      rsp_has_ff  <= rsp_has_in;
      rsp_last_ff <= rsp_last_in;
      rsp_end_ff  <= rsp_end_in;
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.out_byte = rsp_byte_ff;
   assign rsp_bus.has_byte = rsp_has_ff;
   assign rsp_bus.run_last = rsp_last_ff;
   assign rsp_bus.text_end = rsp_end_ff;

   // window never reaches the pattern length between transfers
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff < mlen)
      else $error("window count reached pattern length");

   // a final byte always leaves an empty window
   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready && req_bus.is_final) |=> (count_ff == '0))
      else $error("window not emptied after final byte");

   // end of text only on the last result of a run
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.text_end) |-> rsp_bus.run_last)
      else $error("text end outside last result of a run");

   // an empty result is only ever the end marker
   a_marker_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.has_byte) |-> (rsp_bus.text_end && rsp_bus.out_byte == '0))
      else $error("empty result that is not an end marker");

endmodule

/* sim/sfr_rewrite_checker.sv */
// checker for the stream find-and-replace block: predicts the rewritten text and compares
`timescale 1ns / 100ps

module sfr_rewrite_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [sfr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sfr_pkg::CSR_DATA_W-1:0] csr_data,
   sfr_req_if                             req_mon,
   sfr_rsp_if                             rsp_mon,
   output int                             fail_count,
   output int                             expected_left,
   output int                             results_seen
);

   localparam int LW = sfr_pkg::LEN_W;

   typedef struct packed {
      logic [sfr_pkg::BYTE_W-1:0] out_byte;
      logic                       has_byte;
      logic                       run_last;
      logic                       text_end;
   } rewrite_result_type;

   // mirror of the configuration registers
   logic [sfr_pkg::CSR_DATA_W-1:0] find_pattern;
   logic [LW-1:0]                  find_len;
   logic [sfr_pkg::CSR_DATA_W-1:0] swap_pattern;
   logic [LW-1:0]                  swap_len;

   // predicted window of pending bytes, oldest first
   logic [sfr_pkg::BYTE_W-1:0]     pending_bytes [8];
   int                             pending_count;

   rewrite_result_type             awaited_results [$];

   // rewrite one accepted byte and queue the results it causes
   function automatic void rewrite_byte(input logic [sfr_pkg::BYTE_W-1:0] b, input logic fin);
      rewrite_result_type run [$];
      int                 m;
      int                 k;
      int                 i;
      logic               hit;
      m = (find_len == 0) ? 1 : ((find_len > 8) ? 8 : int'(find_len));
      k = (swap_len > 8) ? 8 : int'(swap_len);
      if (pending_count >= m) pending_count = 0;
      pending_bytes[pending_count] = b;
      pending_count++;
      // full window: replace on a hit, else release the oldest byte
      if (pending_count == m) begin
         hit = 1'b1;
         for (i = 0; i < m; i++)
            if (pending_bytes[i] != find_pattern[8*i +: 8]) hit = 1'b0;
         if (hit) begin
            for (i = 0; i < k; i++)
               run.push_back('{out_byte: swap_pattern[8*i +: 8], has_byte: 1'b1,
                               run_last: 1'b0, text_end: 1'b0});
            pending_count = 0;
         end else begin
            run.push_back('{out_byte: pending_bytes[0], has_byte: 1'b1,
                            run_last: 1'b0, text_end: 1'b0});
            for (i = 1; i < pending_count; i++) pending_bytes[i-1] = pending_bytes[i];
            pending_count--;
         end
      end
      // end of text: flush the window, or give an empty end marker
      if (fin) begin
         for (i = 0; i < pending_count; i++)
            run.push_back('{out_byte: pending_bytes[i], has_byte: 1'b1,
                            run_last: 1'b0, text_end: 1'b0});
         pending_count = 0;
         if (run.size() == 0)
            run.push_back('{out_byte: '0, has_byte: 1'b0, run_last: 1'b0, text_end: 1'b0});
         run[run.size()-1].text_end = 1'b1;
      end
      if (run.size() > 0) run[run.size()-1].run_last = 1'b1;
      foreach (run[j]) awaited_results.push_back(run[j]);
   endfunction

   // register writes, input transfers and output transfers, in that order
   always @(posedge clock) begin
      rewrite_result_type want;
      if (reset) begin
         find_pattern  = '0;
         find_len      = LW'(1);
         swap_pattern  = '0;
         swap_len      = '0;
         pending_count = 0;
         awaited_results.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               sfr_pkg::CSR_MATCH_PATTERN:   find_pattern = csr_data;
               sfr_pkg::CSR_MATCH_LEN: begin
                  find_len      = csr_data[LW-1:0];
                  pending_count = 0;
               end
               sfr_pkg::CSR_REPLACE_PATTERN: swap_pattern = csr_data;
               sfr_pkg::CSR_REPLACE_LEN:     swap_len = csr_data[LW-1:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) rewrite_byte(req_mon.in_byte, req_mon.is_final);
         if (rsp_mon.valid && rsp_mon.ready) begin
            results_seen++;
            if (awaited_results.size() == 0) begin
               fail_count++;
               $error("unexpected result: out_byte %02h has_byte %0b run_last %0b text_end %0b",
                      rsp_mon.out_byte, rsp_mon.has_byte, rsp_mon.run_last, rsp_mon.text_end);
            end else begin
               want = awaited_results.pop_front();
               if (rsp_mon.out_byte !== want.out_byte) begin
                  fail_count++;
                  $error("out_byte: expected %02h, actual %02h", want.out_byte, rsp_mon.out_byte);
               end
               if (rsp_mon.has_byte !== want.has_byte) begin
                  fail_count++;
                  $error("has_byte: expected %0b, actual %0b", want.has_byte, rsp_mon.has_byte);
               end
               if (rsp_mon.run_last !== want.run_last) begin
                  fail_count++;
                  $error("run_last: expected %0b, actual %0b", want.run_last, rsp_mon.run_last);
               end
               if (rsp_mon.text_end !== want.text_end) begin
                  fail_count++;
                  $error("text_end: expected %0b, actual %0b", want.text_end, rsp_mon.text_end);
               end
            end
         end
      end
      expected_left = awaited_results.size();
   end

endmodule

/* sim/stream_find_replace_unit_test.sv */
// testbench top: text stimulus, register settings and verdict for the find-and-replace block
`timescale 1ns / 100ps

module stream_find_replace_unit_test;

   localparam int CYCLE_LIMIT = 600000;
   localparam int LONG_HOLD   = 250;
   localparam int SETTLE      = 20;

   typedef logic [sfr_pkg::BYTE_W-1:0] text_type [$];

   logic                           clock;
   logic                           reset;
   logic                           csr_we;
   logic [sfr_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [sfr_pkg::CSR_DATA_W-1:0] csr_data;

   int  check_failures;
   int  expected_left;
   int  results_seen;
   int  bytes_sent;
   int  texts_sent;
   int  settings_used;
   int  cycle_count;
   int  holds_wanted;
   int  holds_done;
   bit  send_gaps;
   bit  take_gaps;

   sfr_req_if req_bus ();
   sfr_rsp_if rsp_bus ();

   stream_find_replace_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus)
   );

   sfr_rewrite_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .fail_count    (check_failures),
      .expected_left (expected_left),
      .results_seen  (results_seen)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // run limit
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still awaited",
                  cycle_count, expected_left);
         $display("FAIL stream_find_replace_unit");
         $finish;
      end
   end

   // output side: random stalls per result, plus the requested long hold-off
   initial begin
      int w;
      rsp_bus.ready = 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         @(negedge clock);
         if (holds_done < holds_wanted) begin
            w = LONG_HOLD;
            holds_done++;
         end else begin
            w = (take_gaps && $urandom_range(0, 1)) ? $urandom_range(1, 16) : 0;
         end
         if (w > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (w) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   // offer one byte and hold it until the transfer
   task automatic offer_byte(input logic [sfr_pkg::BYTE_W-1:0] b, input logic fin);
      int gap;
      gap = (send_gaps && $urandom_range(0, 1)) ? $urandom_range(1, 16) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.in_byte  <= b;
      req_bus.is_final <= fin;
      do @(posedge clock); while (!req_bus.ready);
      bytes_sent++;
   endtask

   // send a text, optionally closing it with a final byte
   task automatic send_text(input text_type txt, input bit closes);
      foreach (txt[i]) offer_byte(txt[i], closes && (i == txt.size() - 1));
      if (closes) texts_sent++;
   endtask

   // stop offering and let every awaited result drain
   task automatic wait_quiet();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_left != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   // write all four registers, called from a falling edge while idle
   task automatic load_setting(input logic [63:0] pat, input logic [3:0] plen,
                               input logic [63:0] rep, input logic [3:0] rlen);
      csr_we    <= 1'b1;
      csr_index <= sfr_pkg::CSR_MATCH_PATTERN;
      csr_data  <= pat;
      @(negedge clock);
      csr_index <= sfr_pkg::CSR_MATCH_LEN;
      csr_data  <= 64'(plen);
      @(negedge clock);
      csr_index <= sfr_pkg::CSR_REPLACE_PATTERN;
      csr_data  <= rep;
      @(negedge clock);
      csr_index <= sfr_pkg::CSR_REPLACE_LEN;
      csr_data  <= 64'(rlen);
      @(negedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      settings_used++;
   endtask

   initial begin
      text_type    txt;
      logic [63:0] pat;
      logic [63:0] rep;
      logic [3:0]  plen;
      logic [3:0]  rlen;
      int          m;
      int          budget;
      int          target;
      bit          closes;

      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_index        = sfr_pkg::CSR_MATCH_PATTERN;
      csr_data         = '0;
      req_bus.valid    = 1'b0;
      req_bus.in_byte  = '0;
      req_bus.is_final = 1'b0;
      bytes_sent       = 0;
      texts_sent       = 0;
      settings_used    = 0;
      holds_wanted     = 0;
      holds_done       = 0;
      send_gaps        = 1'b1;
      take_gaps        = 1'b1;

      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset setting: single zero byte deleted, empty end marker when nothing is left
      txt = '{8'h00, 8'hFF, 8'h00};
      send_text(txt, 1'b1);
      txt = '{8'h5A};
      send_text(txt, 1'b1);

      // longest pattern of all ones, replacement length saturating to eight
      wait_quiet();
      load_setting(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 64'h0123_4567_89AB_CDEF, 4'd15);
      txt = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
      send_text(txt, 1'b1);

      // zero pattern length taken as one, expansion to eight bytes
      wait_quiet();
      load_setting(64'h0000_0000_0000_0041, 4'd0, 64'h8070_6050_4030_2010, 4'd8);
      txt = '{8'h41, 8'h42};
      send_text(txt, 1'b1);

      // oversize pattern length saturates; window left pending, then discarded
      wait_quiet();
      load_setting(64'h0, 4'd15, 64'hA5A5_A5A5_A5A5_A5A5, 4'd0);
      txt = '{8'h00, 8'h00, 8'h00};
      send_text(txt, 1'b0);

      // partial match then a hit, and a new text after the final byte
      wait_quiet();
      load_setting(64'h0000_0000_0063_6261, 4'd3, 64'h0000_0000_0000_7978, 4'd2);
      txt = '{8'h61, 8'h62, 8'h61, 8'h62, 8'h63};
      send_text(txt, 1'b1);
      txt = '{8'h63};
      send_text(txt, 1'b1);

      // random settings, each followed by a burst of texts
      for (int phase = 0; phase < 12; phase++) begin
         plen = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                            : 4'($urandom_range(1, 8));
         rlen = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                            : 4'($urandom_range(0, 8));
         if ($urandom_range(0, 1)) begin
            for (int i = 0; i < 8; i++) pat[8*i +: 8] = 8'h61 + 8'($urandom_range(0, 2));
         end else begin
            pat = {$urandom, $urandom};
         end
         rep = {$urandom, $urandom};
         m = (plen == 0) ? 1 : ((plen > 8) ? 8 : int'(plen));

         wait_quiet();
         load_setting(pat, plen, rep, rlen);
         send_gaps = ($urandom_range(0, 3) != 0);
         take_gaps = ($urandom_range(0, 3) != 0);
         budget    = 22;
         // one phase streams hard into a long output hold-off
         if (phase == 3) begin
            send_gaps    = 1'b0;
            take_gaps    = 1'b1;
            holds_wanted = holds_wanted + 1;
            budget       = 40;
         end

         while (budget > 0) begin
            txt.delete();
            target = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 24)
                                                 : $urandom_range(1, 12);
            while (txt.size() < target) begin
               case ($urandom_range(0, 9))
                  0, 1, 2: begin
                     // occurrence of the pattern, sometimes with its last byte broken
                     for (int i = 0; i < m; i++) txt.push_back(pat[8*i +: 8]);
                     if ($urandom_range(0, 3) == 0)
                        txt[txt.size()-1] = txt[txt.size()-1] ^ 8'($urandom_range(1, 255));
                  end
                  3, 4, 5: txt.push_back(pat[8*$urandom_range(0, m-1) +: 8]);
                  6:       txt.push_back(rep[8*$urandom_range(0, 7) +: 8]);
                  default: txt.push_back(8'($urandom_range(0, 255)));
               endcase
            end
            budget -= txt.size();
            closes = (budget > 0) || ($urandom_range(0, 2) != 0);
            send_text(txt, closes);
         end
      end

      send_gaps = 1'b1;
      take_gaps = 1'b1;
      wait_quiet();

      $display("checked %0d results from %0d input bytes over %0d closed texts",
               results_seen, bytes_sent, texts_sent);
      $display("%0d register settings, including zero and oversize lengths, one long hold-off",
               settings_used);
      if (check_failures == 0 && expected_left == 0) begin
         $display("PASS stream_find_replace_unit");
      end else begin
         $display("FAIL stream_find_replace_unit");
      end
      $finish;
   end

endmodule
